// ===== src/pdc_pkg.sv =====
// Shared types, codes and helper functions of the parameter download controller.
package pdc_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'd1;

  localparam logic [15:0] ADDR_LIMIT_RST = 16'hFFFF;
  localparam logic [7:0]  MAX_LEN_RST    = 8'hFF;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // CRC-16 constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Raw input kind codes
  localparam logic [2:0] KIND_CODE_MODE  = 3'd0;
  localparam logic [2:0] KIND_CODE_CMD   = 3'd1;
  localparam logic [2:0] KIND_CODE_HDR   = 3'd2;
  localparam logic [2:0] KIND_CODE_DATA  = 3'd3;
  localparam logic [2:0] KIND_CODE_CHECK = 3'd4;
  localparam logic [2:0] KIND_CODE_MEM   = 3'd5;

  // Raw command codes
  localparam logic [7:0] OP_READ   = 8'd0;
  localparam logic [7:0] OP_WRITE  = 8'd1;
  localparam logic [7:0] OP_BACKUP = 8'd2;

  // Result codes
  localparam logic [3:0] RES_IDLE      = 4'd0;
  localparam logic [3:0] RES_READING   = 4'd1;
  localparam logic [3:0] RES_READ_OK   = 4'd2;
  localparam logic [3:0] RES_READ_FAIL = 4'd3;
  localparam logic [3:0] RES_AWAIT_WR  = 4'd4;
  localparam logic [3:0] RES_WRITE_OK  = 4'd5;
  localparam logic [3:0] RES_WRITE_FAIL = 4'd6;
  localparam logic [3:0] RES_BACKUP_OK = 4'd7;
  localparam logic [3:0] RES_BACKUP_FAIL = 4'd8;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CMD  = 3'd1;
  localparam logic [2:0] ERR_NOT_CFG  = 3'd2;
  localparam logic [2:0] ERR_LIMITS   = 3'd3;
  localparam logic [2:0] ERR_MEMORY   = 3'd4;
  localparam logic [2:0] ERR_NOT_AWAIT = 3'd5;
  localparam logic [2:0] ERR_MISMATCH = 3'd6;

  // Memory request codes
  localparam logic [1:0] MREQ_NONE   = 2'd0;
  localparam logic [1:0] MREQ_READ   = 2'd1;
  localparam logic [1:0] MREQ_STORE  = 2'd2;
  localparam logic [1:0] MREQ_BACKUP = 2'd3;

  // Classified item kind; unused raw kinds fold into KIND_NONE
  typedef enum logic [2:0] {
    KIND_MODE,
    KIND_CMD,
    KIND_HDR,
    KIND_DATA,
    KIND_CHECK,
    KIND_MEM,
    KIND_NONE
  } kind_e;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_BACKUP,
    CMD_BAD
  } cmd_e;

  // Live configuration registers
  typedef struct packed {
    logic [15:0] addr_limit;
    logic [7:0]  max_len;
  } cfg_t;

  // Classified item as it travels from front to back
  typedef struct packed {
    kind_e       kind;
    cmd_e        cmd;
    logic        mode_ok;
    logic        mode_val;
    logic        read_bad;
    logic        backup_bad;
    logic [15:0] start_addr;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
    logic [15:0] rx_check;
    logic        mem_ok;
  } entry_t;

  // Fold one byte into the CRC, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = c ^ CRC_POLY;
      end
      c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  // Transfer limit check: end address, length ceiling and zero length
  function automatic logic limits_bad(input logic [15:0] addr, input logic [7:0] len,
                                      input cfg_t cfg);
    logic [16:0] end_addr;
    end_addr = {1'b0, addr} + {9'd0, len};
    return (end_addr > {1'b0, cfg.addr_limit}) || (len > cfg.max_len) || (len == 8'd0);
  endfunction

endpackage

// ===== src/pdc_if.sv =====
// Input and result channel interfaces of the parameter download controller.
interface pdc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  mode_value;
  logic [7:0]  op;
  logic [15:0] start_addr;
  logic [7:0]  byte_count;
  logic [7:0]  data_byte;
  logic [15:0] rx_check;
  logic        mem_ok;

  modport source (
    output valid, kind, mode_value, op, start_addr, byte_count, data_byte, rx_check, mem_ok,
    input  ready
  );
  modport sink (
    input  valid, kind, mode_value, op, start_addr, byte_count, data_byte, rx_check, mem_ok,
    output ready
  );
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic        mode_active;
  logic [3:0]  result_code;
  logic [2:0]  error_code;
  logic [15:0] crc_out;
  logic [1:0]  mem_request;
  logic [15:0] req_addr;
  logic [7:0]  req_len;

  modport source (
    output valid, mode_active, result_code, error_code, crc_out, mem_request, req_addr,
           req_len,
    input  ready
  );
  modport sink (
    input  valid, mode_active, result_code, error_code, crc_out, mem_request, req_addr,
           req_len,
    output ready
  );
endinterface

// ===== src/param_download_ctrl_crc16.sv =====
// Top level of the parameter download controller with CRC-16 check.
//
//   channel   dir   handshake       beat
//   in_ch     in    valid/ready     one command, header, data, check or outcome item
//   out_ch    out   valid/ready     one status result per input beat
//   cfg       in    cfg_we_i        one register write, no back-pressure
//
// One beat a cycle sustained while out_ch is not stalled: the front classifies a beat
// in its accept cycle, the back folds one byte into the CRC (eight bit steps) and
// updates state. An accepted beat is written into the queue, and the back registers
// its result when it pops it. The queue lets the input keep flowing for its depth
// while out_ch is stalled. Reset is asynchronous; in_ch is ready out of reset.
module param_download_ctrl_crc16 #(
  parameter int unsigned QueueDepth = pdc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pdc_in_if.sink                         in_ch,
  pdc_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pdc_pkg::*;

  cfg_t   cfg_q;
  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.addr_limit <= ADDR_LIMIT_RST;
      cfg_q.max_len    <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_LIMIT: cfg_q.addr_limit <= cfg_data_i;
        CFG_MAX_LEN:    cfg_q.max_len    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  pdc_front u_front (
    .in_ch    (in_ch),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  pdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  pdc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

  // CRC is reported only with a successful read
  a_crc_only_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.result_code != RES_READ_OK |-> out_ch.crc_out == 16'h0000)
    else $error("crc_out nonzero outside read ok");

  // Without a request, address and length are zero
  a_no_req_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.mem_request == MREQ_NONE |->
      out_ch.req_addr == 16'h0000 && out_ch.req_len == 8'h00)
    else $error("request fields set without request");

  // Requests only issue in configure mode
  a_req_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.mem_request != MREQ_NONE |-> out_ch.mode_active)
    else $error("memory request outside configure mode");

  // A store request leaves the block awaiting the write outcome
  a_store_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.mem_request == MREQ_STORE |-> out_ch.result_code == RES_AWAIT_WR)
    else $error("store request with wrong result code");

  // Backup request carries no length and reports backup ok
  a_backup_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.mem_request == MREQ_BACKUP |->
      out_ch.req_len == 8'h00 && out_ch.result_code == RES_BACKUP_OK)
    else $error("backup request malformed");

endmodule

// ===== src/pdc_front.sv =====
// Front end: accept input beats, classify them and precheck command limits.
module pdc_front (
  pdc_in_if.sink          in_ch,
  input  pdc_pkg::cfg_t   cfg_i,
  input  logic            q_full_i,
  output logic            push_o,
  output pdc_pkg::entry_t entry_o
);
  import pdc_pkg::*;

  // Take a beat whenever the queue has room
  assign in_ch.ready = !q_full_i;
  assign push_o      = in_ch.valid && !q_full_i;

  // Classify kind and command, precompute command checks
  always_comb begin
    entry_o = '0;
    unique case (in_ch.kind)
      KIND_CODE_MODE:  entry_o.kind = KIND_MODE;
      KIND_CODE_CMD:   entry_o.kind = KIND_CMD;
      KIND_CODE_HDR:   entry_o.kind = KIND_HDR;
      KIND_CODE_DATA:  entry_o.kind = KIND_DATA;
      KIND_CODE_CHECK: entry_o.kind = KIND_CHECK;
      KIND_CODE_MEM:   entry_o.kind = KIND_MEM;
      default:         entry_o.kind = KIND_NONE;
    endcase
    unique case (in_ch.op)
      OP_READ:   entry_o.cmd = CMD_READ;
      OP_WRITE:  entry_o.cmd = CMD_WRITE;
      OP_BACKUP: entry_o.cmd = CMD_BACKUP;
      default:   entry_o.cmd = CMD_BAD;
    endcase
    entry_o.mode_ok    = (in_ch.mode_value[7:1] == 7'd0);
    entry_o.mode_val   = in_ch.mode_value[0];
    entry_o.read_bad   = limits_bad(in_ch.start_addr, in_ch.byte_count, cfg_i);
    entry_o.backup_bad = (in_ch.start_addr >= cfg_i.addr_limit);
    entry_o.start_addr = in_ch.start_addr;
    entry_o.byte_count = in_ch.byte_count;
    entry_o.data_byte  = in_ch.data_byte;
    entry_o.rx_check   = in_ch.rx_check;
    entry_o.mem_ok     = in_ch.mem_ok;
  end

endmodule

// ===== src/pdc_queue.sv =====
// Short FIFO of classified items between front and back.
module pdc_queue #(
  parameter int unsigned Depth = pdc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdc_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output pdc_pkg::entry_t head_entry_o
);
  import pdc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == DepthCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ===== src/pdc_back.sv =====
// Back end: carry out classified items on the controller state, register results.
module pdc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pdc_pkg::cfg_t   cfg_i,
  input  logic            head_valid_i,
  input  pdc_pkg::entry_t head_entry_i,
  output logic            pop_o,
  pdc_out_if.source       out_ch
);
  import pdc_pkg::*;

  logic        mode_q, mode_d;
  logic [3:0]  res_q, res_d;
  logic [2:0]  err_q, err_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] paddr_q, paddr_d;
  logic [7:0]  plen_q, plen_d;
  logic        passed_q, passed_d;
  logic [1:0]  req_d;
  logic [15:0] raddr_d;
  logic [7:0]  rlen_d;

  logic        ovalid_q;
  logic        omode_q;
  logic [3:0]  ores_q;
  logic [2:0]  oerr_q;
  logic [15:0] ocrc_q;
  logic [1:0]  oreq_q;
  logic [15:0] oaddr_q;
  logic [7:0]  olen_q;

  entry_t e;
  assign e = head_entry_i;

  // Pop when the result register is free or being drained
  assign pop_o = head_valid_i && (!ovalid_q || out_ch.ready);

  // Next controller state and memory request
  always_comb begin
    mode_d   = mode_q;
    res_d    = res_q;
    err_d    = err_q;
    crc_d    = crc_q;
    paddr_d  = paddr_q;
    plen_d   = plen_q;
    passed_d = passed_q;
    req_d    = MREQ_NONE;
    raddr_d  = '0;
    rlen_d   = '0;
    unique case (e.kind) inside
      KIND_MODE: begin
        if (e.mode_ok) begin
          mode_d = e.mode_val;
          err_d  = ERR_NONE;
        end else begin
          err_d = ERR_BAD_CMD;
        end
      end
      KIND_CMD: begin
        if (!mode_q) begin
          err_d = ERR_NOT_CFG;
        end else begin
          unique case (e.cmd)
            CMD_READ: begin
              if (e.read_bad) begin
                res_d = RES_READ_FAIL;
                err_d = ERR_LIMITS;
              end else begin
                res_d    = RES_READING;
                crc_d    = CRC_INIT;
                paddr_d  = e.start_addr;
                plen_d   = e.byte_count;
                passed_d = 1'b0;
                req_d    = MREQ_READ;
                raddr_d  = e.start_addr;
                rlen_d   = e.byte_count;
              end
            end
            CMD_WRITE: begin
              res_d    = RES_AWAIT_WR;
              err_d    = ERR_NONE;
              paddr_d  = '0;
              plen_d   = '0;
              passed_d = 1'b0;
              crc_d    = CRC_INIT;
            end
            CMD_BACKUP: begin
              if (e.backup_bad) begin
                res_d = RES_BACKUP_FAIL;
                err_d = ERR_LIMITS;
              end else begin
                res_d   = RES_BACKUP_OK;
                err_d   = ERR_NONE;
                req_d   = MREQ_BACKUP;
                raddr_d = e.start_addr;
              end
            end
            default: begin
              res_d = RES_IDLE;
              err_d = ERR_BAD_CMD;
            end
          endcase
        end
      end
      KIND_HDR, KIND_CHECK: begin
        if (!mode_q) begin
          err_d = ERR_NOT_CFG;
        end else if (res_q != RES_AWAIT_WR || passed_q) begin
          err_d = ERR_NOT_AWAIT;
        end else if (e.kind == KIND_HDR) begin
          paddr_d = e.start_addr;
          plen_d  = e.byte_count;
          crc_d   = CRC_INIT;
        end else if (limits_bad(paddr_q, plen_q, cfg_i)) begin
          res_d = RES_WRITE_FAIL;
          err_d = ERR_LIMITS;
        end else if (crc_q != e.rx_check) begin
          res_d = RES_WRITE_FAIL;
          err_d = ERR_MISMATCH;
        end else begin
          passed_d = 1'b1;
          req_d    = MREQ_STORE;
          raddr_d  = paddr_q;
          rlen_d   = plen_q;
        end
      end
      KIND_DATA: begin
        if (mode_q && (res_q == RES_READING || (res_q == RES_AWAIT_WR && !passed_q))) begin
          crc_d = crc_byte(crc_q, e.data_byte);
        end
      end
      KIND_MEM: begin
        if (res_q == RES_READING) begin
          res_d = e.mem_ok ? RES_READ_OK : RES_READ_FAIL;
          err_d = e.mem_ok ? ERR_NONE : ERR_MEMORY;
        end else if (res_q == RES_AWAIT_WR && passed_q) begin
          res_d    = e.mem_ok ? RES_WRITE_OK : RES_WRITE_FAIL;
          err_d    = e.mem_ok ? ERR_NONE : ERR_MEMORY;
          passed_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Controller state and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      res_q    <= RES_IDLE;
      err_q    <= ERR_NONE;
      crc_q    <= CRC_INIT;
      paddr_q  <= '0;
      plen_q   <= '0;
      passed_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q   <= mode_d;
        res_q    <= res_d;
        err_q    <= err_d;
        crc_q    <= crc_d;
        paddr_q  <= paddr_d;
        plen_q   <= plen_d;
        passed_q <= passed_d;
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      omode_q <= mode_d;
      ores_q  <= res_d;
      oerr_q  <= err_d;
      ocrc_q  <= (res_d == RES_READ_OK) ? crc_d : 16'h0000;
      oreq_q  <= req_d;
      oaddr_q <= raddr_d;
      olen_q  <= rlen_d;
    end
  end

  assign out_ch.valid       = ovalid_q;
  assign out_ch.mode_active = omode_q;
  assign out_ch.result_code = ores_q;
  assign out_ch.error_code  = oerr_q;
  assign out_ch.crc_out     = ocrc_q;
  assign out_ch.mem_request = oreq_q;
  assign out_ch.req_addr    = oaddr_q;
  assign out_ch.req_len     = olen_q;

endmodule

// ===== verif/param_download_ctrl_crc16_tb.sv =====
// Self-checking testbench for the parameter download controller with CRC-16 check.
module param_download_ctrl_crc16_tb;
  import pdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  // Raw kind code that the block leaves unused
  localparam logic [2:0] KIND_CODE_SPARE = 3'd6;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  mode_value;
    logic [7:0]  op;
    logic [15:0] start_addr;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
    logic [15:0] rx_check;
    logic        mem_ok;
  } dl_item_t;

  typedef struct packed {
    logic        mode_active;
    logic [3:0]  result_code;
    logic [2:0]  error_code;
    logic [15:0] crc_out;
    logic [1:0]  mem_request;
    logic [15:0] req_addr;
    logic [7:0]  req_len;
  } dl_status_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  param_download_ctrl_crc16 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Controller model state and its copy of the registers
  logic        ctl_mode;
  logic [3:0]  ctl_result;
  logic [2:0]  ctl_error;
  logic [15:0] ctl_crc;
  logic [15:0] ctl_addr;
  logic [7:0]  ctl_len;
  logic        ctl_store_pending;
  logic [15:0] cfg_addr_limit;
  logic [7:0]  cfg_max_len;

  dl_item_t   pending_items[$];
  dl_status_t expected_status[$];
  int unsigned issued = 0;
  int unsigned status_mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap;
  int unsigned snk_stall;
  logic        beat_taken;
  logic        src_idle_en = 1'b1;
  logic        snk_idle_en = 1'b1;

  // Fold one byte into the running CRC: xor the byte in, then eight steps
  function automatic logic [15:0] fold_crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c ^ CRC_POLY) >> 1) : (c >> 1);
    return c;
  endfunction

  // Transfer is rejected on end address, length ceiling or zero length
  function automatic logic xfer_out_of_range(input logic [15:0] a, input logic [7:0] n);
    logic [16:0] last;
    last = {1'b0, a} + {9'd0, n};
    return (last > {1'b0, cfg_addr_limit}) || (n > cfg_max_len) || (n == 8'd0);
  endfunction

  // Apply one accepted beat to the model and return the status it produces
  function automatic dl_status_t advance_controller(input dl_item_t it);
    dl_status_t r;
    r = '0;
    case (it.kind) inside
      KIND_CODE_MODE: begin
        if (it.mode_value < 8'd2) begin
          ctl_mode  = it.mode_value[0];
          ctl_error = ERR_NONE;
        end else begin
          ctl_error = ERR_BAD_CMD;
        end
      end
      KIND_CODE_CMD: begin
        if (!ctl_mode) begin
          ctl_error = ERR_NOT_CFG;
        end else if (it.op == OP_READ) begin
          if (xfer_out_of_range(it.start_addr, it.byte_count)) begin
            ctl_result = RES_READ_FAIL;
            ctl_error  = ERR_LIMITS;
          end else begin
            ctl_result        = RES_READING;
            ctl_crc           = CRC_INIT;
            ctl_addr          = it.start_addr;
            ctl_len           = it.byte_count;
            ctl_store_pending = 1'b0;
            r.mem_request     = MREQ_READ;
            r.req_addr        = it.start_addr;
            r.req_len         = it.byte_count;
          end
        end else if (it.op == OP_WRITE) begin
          ctl_result        = RES_AWAIT_WR;
          ctl_error         = ERR_NONE;
          ctl_addr          = '0;
          ctl_len           = '0;
          ctl_store_pending = 1'b0;
          ctl_crc           = CRC_INIT;
        end else if (it.op == OP_BACKUP) begin
          if (it.start_addr >= cfg_addr_limit) begin
            ctl_result = RES_BACKUP_FAIL;
            ctl_error  = ERR_LIMITS;
          end else begin
            ctl_result    = RES_BACKUP_OK;
            ctl_error     = ERR_NONE;
            r.mem_request = MREQ_BACKUP;
            r.req_addr    = it.start_addr;
          end
        end else begin
          ctl_result = RES_IDLE;
          ctl_error  = ERR_BAD_CMD;
        end
      end
      KIND_CODE_HDR, KIND_CODE_CHECK: begin
        if (!ctl_mode) begin
          ctl_error = ERR_NOT_CFG;
        end else if (ctl_result != RES_AWAIT_WR || ctl_store_pending) begin
          ctl_error = ERR_NOT_AWAIT;
        end else if (it.kind == KIND_CODE_HDR) begin
          ctl_addr = it.start_addr;
          ctl_len  = it.byte_count;
          ctl_crc  = CRC_INIT;
        end else if (xfer_out_of_range(ctl_addr, ctl_len)) begin
          ctl_result = RES_WRITE_FAIL;
          ctl_error  = ERR_LIMITS;
        end else if (ctl_crc != it.rx_check) begin
          ctl_result = RES_WRITE_FAIL;
          ctl_error  = ERR_MISMATCH;
        end else begin
          ctl_store_pending = 1'b1;
          r.mem_request     = MREQ_STORE;
          r.req_addr        = ctl_addr;
          r.req_len         = ctl_len;
        end
      end
      KIND_CODE_DATA: begin
        if (ctl_mode && (ctl_result == RES_READING ||
                         (ctl_result == RES_AWAIT_WR && !ctl_store_pending))) begin
          ctl_crc = fold_crc_byte(ctl_crc, it.data_byte);
        end
      end
      KIND_CODE_MEM: begin
        if (ctl_result == RES_READING) begin
          ctl_result = it.mem_ok ? RES_READ_OK : RES_READ_FAIL;
          ctl_error  = it.mem_ok ? ERR_NONE : ERR_MEMORY;
        end else if (ctl_result == RES_AWAIT_WR && ctl_store_pending) begin
          ctl_result        = it.mem_ok ? RES_WRITE_OK : RES_WRITE_FAIL;
          ctl_error         = it.mem_ok ? ERR_NONE : ERR_MEMORY;
          ctl_store_pending = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.mode_active = ctl_mode;
    r.result_code = ctl_result;
    r.error_code  = ctl_error;
    r.crc_out     = (ctl_result == RES_READ_OK) ? ctl_crc : 16'h0000;
    return r;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Fully random beat; fields that the kind does not use stay random
  function automatic dl_item_t random_item();
    dl_item_t it;
    it.kind       = 3'($urandom_range(0, 7));
    it.mode_value = 8'($urandom);
    it.op         = 8'($urandom);
    it.start_addr = 16'($urandom);
    it.byte_count = 8'($urandom);
    it.data_byte  = 8'($urandom);
    it.rx_check   = 16'($urandom);
    it.mem_ok     = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(input dl_item_t it);
    pending_items.push_back(it);
    issued++;
  endtask

  task automatic push_kind(input logic [2:0] k);
    dl_item_t it;
    it = random_item();
    it.kind = k;
    push_item(it);
  endtask

  task automatic push_mode(input logic [7:0] v);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_MODE;
    it.mode_value = v;
    push_item(it);
  endtask

  task automatic push_cmd(input logic [7:0] op, input logic [15:0] a, input logic [7:0] n);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_CMD;
    it.op = op;
    it.start_addr = a;
    it.byte_count = n;
    push_item(it);
  endtask

  task automatic push_hdr(input logic [15:0] a, input logic [7:0] n);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_HDR;
    it.start_addr = a;
    it.byte_count = n;
    push_item(it);
  endtask

  task automatic push_data(input logic [7:0] b);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_DATA;
    it.data_byte = b;
    push_item(it);
  endtask

  task automatic push_check(input logic [15:0] rx);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_CHECK;
    it.rx_check = rx;
    push_item(it);
  endtask

  task automatic push_mem(input logic ok);
    dl_item_t it;
    it = random_item();
    it.kind = KIND_CODE_MEM;
    it.mem_ok = ok;
    push_item(it);
  endtask

  // Pick a transfer, mostly inside the current limits and mostly short
  task automatic pick_transfer(output logic [15:0] a, output logic [7:0] n);
    int unsigned top;
    if ($urandom_range(0, 9) == 0) begin
      a = 16'($urandom);
      n = 8'($urandom);
    end else begin
      top = ({8'd0, cfg_max_len} < cfg_addr_limit) ? 32'(cfg_max_len) : 32'(cfg_addr_limit);
      if (top > 8 && $urandom_range(0, 19) != 0) top = 8;
      n = 8'($urandom_range(1, top));
      a = 16'($urandom_range(0, cfg_addr_limit - {8'd0, n}));
      // land one past the allowed end now and then
      if ($urandom_range(0, 14) == 0) a = cfg_addr_limit - {8'd0, n} + 16'd1;
    end
  endtask

  task automatic queue_read_sequence();
    logic [15:0] a;
    logic [7:0]  n;
    int unsigned nbytes;
    pick_transfer(a, n);
    push_cmd(OP_READ, a, n);
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 32'(n);
    repeat (nbytes) push_data(8'($urandom));
    push_mem($urandom_range(0, 7) != 0);
  endtask

  task automatic queue_write_sequence();
    logic [15:0] a;
    logic [7:0]  n;
    logic [15:0] sum;
    logic [7:0]  b;
    int unsigned nbytes;
    push_cmd(OP_WRITE, 16'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) != 0) begin
      pick_transfer(a, n);
      push_hdr(a, n);
      sum = CRC_INIT;
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 32'(n);
      repeat (nbytes) begin
        b = 8'($urandom);
        sum = fold_crc_byte(sum, b);
        push_data(b);
      end
      // corrupt the check now and then
      if ($urandom_range(0, 6) == 0) sum = sum ^ (16'd1 << $urandom_range(0, 15));
      push_check(sum);
    end else begin
      push_check(16'($urandom));
    end
    // stray header, check or payload before the memory outcome
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) != 0) push_hdr(16'($urandom), 8'($urandom));
      else push_check(16'($urandom));
    end
    if ($urandom_range(0, 6) == 0) push_data(8'($urandom));
    push_mem($urandom_range(0, 7) != 0);
  endtask

  task automatic queue_backup();
    logic [15:0] a;
    if ($urandom_range(0, 4) == 0) begin
      a = ($urandom_range(0, 1) != 0) ? cfg_addr_limit : 16'($urandom);
    end else begin
      a = 16'($urandom_range(0, cfg_addr_limit - 16'd1));
    end
    push_cmd(OP_BACKUP, a, 8'($urandom));
  endtask

  // Directed opening: field extremes, every op and each corner case
  task automatic queue_directed();
    logic [15:0] sum;
    push_cmd(OP_READ, 16'h0000, 8'd1);        // command before configure mode
    push_mode(8'd2);                          // bad mode value
    push_mode(8'd1);
    push_cmd(8'hFF, 16'hFFFF, 8'hFF);         // unknown op
    push_cmd(OP_READ, 16'h0000, 8'd0);        // zero length
    push_cmd(OP_READ, 16'hFFFF, 8'hFF);       // end address carries out
    push_hdr(16'h0000, 8'd1);                 // header while not awaiting write
    push_cmd(OP_READ, 16'h0010, 8'd2);
    push_data(8'hFF);
    push_data(8'h00);
    push_mem(1'b1);                           // read ok with CRC
    push_cmd(OP_READ, 16'hFF00, 8'hFF);       // end exactly at the limit
    push_mem(1'b0);                           // read fail on memory error
    push_cmd(OP_WRITE, 16'h0000, 8'd0);
    push_check(16'h0000);                     // check with no header
    push_cmd(OP_WRITE, 16'h0000, 8'd0);
    push_hdr(16'h0020, 8'd2);
    push_data(8'h12);
    push_data(8'h34);
    sum = fold_crc_byte(fold_crc_byte(CRC_INIT, 8'h12), 8'h34);
    push_check(sum);                          // match, store issued
    push_hdr(16'h0040, 8'd1);                 // header while store outstanding
    push_mem(1'b1);
    push_cmd(OP_WRITE, 16'h0000, 8'd0);
    push_hdr(16'h0030, 8'd1);
    push_data(8'h77);
    push_check(~fold_crc_byte(CRC_INIT, 8'h77)); // check mismatch
    push_cmd(OP_BACKUP, 16'h0000, 8'd0);
    push_cmd(OP_BACKUP, 16'hFFFF, 8'd0);      // backup at the address limit
    push_kind(KIND_CODE_SPARE);
    push_mode(8'd0);
    push_data(8'hA5);                         // ignored outside configure mode
  endtask

  // Mostly well-formed transfers, with noise and broken sequences mixed in
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned first;
    int unsigned r;
    dl_item_t    it;
    @(negedge clk_i);
    first = issued;
    push_mode(8'd1);
    while (issued - first < count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_read_sequence();
      end else if (r < 62) begin
        queue_write_sequence();
      end else if (r < 72) begin
        queue_backup();
      end else if (r < 90) begin
        push_item(random_item());
      end else if (r < 95) begin
        push_cmd(8'($urandom_range(3, 255)), 16'($urandom), 8'($urandom));
      end else begin
        // drop out of configure mode, poke it, and come back
        push_mode(8'd0);
        repeat ($urandom_range(1, 3)) begin
          it = random_item();
          it.kind = ($urandom_range(0, 1) != 0) ? KIND_CODE_CMD : KIND_CODE_CHECK;
          push_item(it);
        end
        push_mode(($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255)) : 8'd1);
        push_mode(8'd1);
      end
    end
  endtask

  // Hold until every beat is sent and every status has come back
  task automatic wait_until_drained();
    @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || expected_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_ADDR_LIMIT) cfg_addr_limit = value;
    else cfg_max_len = value[7:0];
  endtask

  // Drive input beats from the pending queue, with random gaps after beats while source idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.kind        <= KIND_CODE_MODE;
      in_ch.mode_value  <= '0;
      in_ch.op          <= OP_READ;
      in_ch.start_addr  <= '0;
      in_ch.byte_count  <= '0;
      in_ch.data_byte   <= '0;
      in_ch.rx_check    <= '0;
      in_ch.mem_ok      <= 1'b0;
      src_gap           = 0;
      ctl_mode          = 1'b0;
      ctl_result        = RES_IDLE;
      ctl_error         = ERR_NONE;
      ctl_crc           = CRC_INIT;
      ctl_addr          = '0;
      ctl_len           = '0;
      ctl_store_pending = 1'b0;
    end else begin
      beat_taken = in_ch.valid && in_ch.ready;
      if (beat_taken) begin
        expected_status.push_back(advance_controller(pending_items[0]));
        void'(pending_items.pop_front());
        src_gap = src_idle_en ? draw_gap() : 0;
      end
      if (!in_ch.valid || beat_taken) begin
        if (src_gap > 0) begin
          in_ch.valid <= 1'b0;
          src_gap--;
        end else if (pending_items.size() != 0) begin
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= pending_items[0].kind;
          in_ch.mode_value <= pending_items[0].mode_value;
          in_ch.op         <= pending_items[0].op;
          in_ch.start_addr <= pending_items[0].start_addr;
          in_ch.byte_count <= pending_items[0].byte_count;
          in_ch.data_byte  <= pending_items[0].data_byte;
          in_ch.rx_check   <= pending_items[0].rx_check;
          in_ch.mem_ok     <= pending_items[0].mem_ok;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check each result beat against the oldest expected status; stall at random while sink idling is on
  always @(posedge clk_i or negedge rst_ni) begin : status_monitor
    dl_status_t got;
    dl_status_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.mode_active, out_ch.result_code, out_ch.error_code, out_ch.crc_out,
               out_ch.mem_request, out_ch.req_addr, out_ch.req_len};
        if (expected_status.size() == 0) begin
          status_mismatches++;
          $display("%0t: unexpected result: expected none, got %p", $time, got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            status_mismatches++;
            $display("%0t: result mismatch: expected %p", $time, want);
            $display("%0t:                  actual   %p", $time, got);
          end
        end
      end
      if (snk_stall > 0) begin
        out_ch.ready <= 1'b0;
        snk_stall--;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        snk_stall = draw_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ADDR_LIMIT;
    cfg_data_i     = '0;
    cfg_addr_limit = ADDR_LIMIT_RST;
    cfg_max_len    = MAX_LEN_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits
    queue_directed();
    queue_random_traffic(230);
    wait_until_drained();

    // tightest limits
    write_register(CFG_ADDR_LIMIT, 16'd1);
    write_register(CFG_MAX_LEN, 16'd1);
    queue_random_traffic(220);
    wait_until_drained();

    // small window, no idling on either side
    write_register(CFG_ADDR_LIMIT, 16'h0040);
    write_register(CFG_MAX_LEN, 16'd16);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    queue_random_traffic(270);
    wait_until_drained();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    // random limits
    write_register(CFG_ADDR_LIMIT, 16'($urandom_range(1, 65535)));
    write_register(CFG_MAX_LEN, 16'($urandom_range(1, 255)));
    queue_random_traffic(270);
    wait_until_drained();

    // widest limits, written explicitly
    write_register(CFG_ADDR_LIMIT, 16'hFFFF);
    write_register(CFG_MAX_LEN, 16'd255);
    queue_random_traffic(300);
    wait_until_drained();

    // address limit just above the length ceiling
    write_register(CFG_ADDR_LIMIT, 16'd300);
    write_register(CFG_MAX_LEN, 16'd255);
    queue_random_traffic(280);
    wait_until_drained();

    repeat (8) @(posedge clk_i);
    if (status_mismatches == 0 && expected_status.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
